// File: rtl/lhs_pkg.sv
// ----------------------------------------------------------------------------
// Latency histogram statistics package
// Widths, slot counts and register map shared by the statistics unit.
// ----------------------------------------------------------------------------
package lhs_pkg;

	// Width of a sample and of every statistic.
	localparam int DATA_W = 32;

	// Edge registers that exist, and how many of them take part in binning.
	localparam int EDGE_SLOTS = 4;
	localparam int NUM_EDGES  = 4;

	// Bins 0 to EDGE_SLOTS-1, then the overflow bin.
	localparam int BIN_SLOTS = EDGE_SLOTS + 1;
	localparam int BIN_OVER  = EDGE_SLOTS;

	// Register port: one 32-bit word per edge register at byte address 4*i.
	localparam int EDGE_IDX_W = $clog2(EDGE_SLOTS);
	localparam int ADDR_W     = EDGE_IDX_W + 2;

	// Divider step counter.
	localparam int CNT_W = $clog2(DATA_W);

	typedef logic [DATA_W-1:0] word_t;

endpackage

// File: rtl/latency_histogram_stats_unit.sv
// The result word is registered after bit-serial division for the mean: the
// divider runs in S_DIV, then S_HOLD registers the word once the output is free.
// The radix-2 divider keeps in_stall high from the taken sample until its word
// is loaded. A new sample is taken while the previous result word still waits.
// Reset (arst_n low) clears all statistics and counters and sets every edge
// register to all ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Latency histogram statistics unit
// Keeps running minimum, maximum, sum, count, mean, drop count and a
// five-bin histogram of latency samples, reporting all of them per sample.
// ----------------------------------------------------------------------------
module latency_histogram_stats_unit #(
	parameter int NUM_EDGES = lhs_pkg::NUM_EDGES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lhs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  lhs_pkg::word_t             sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       accepted,
	output lhs_pkg::word_t             sample_count,
	output lhs_pkg::word_t             min_value,
	output lhs_pkg::word_t             max_value,
	output lhs_pkg::word_t             total,
	output lhs_pkg::word_t             mean,
	output lhs_pkg::word_t             dropped,
	output lhs_pkg::word_t             hist_0,
	output lhs_pkg::word_t             hist_1,
	output lhs_pkg::word_t             hist_2,
	output lhs_pkg::word_t             hist_3,
	output lhs_pkg::word_t             hist_over
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_HOLD
	} state_t;

	state_t                       state_q;
	lhs_pkg::word_t               edge_q [lhs_pkg::EDGE_SLOTS];
	lhs_pkg::word_t               acc_count_q;
	lhs_pkg::word_t               acc_min_q;
	lhs_pkg::word_t               acc_max_q;
	lhs_pkg::word_t               acc_sum_q;
	lhs_pkg::word_t               lost_q;
	lhs_pkg::word_t               bin_q [lhs_pkg::BIN_SLOTS];
	logic                         ok_q;

	// Divider: remainder, and the dividend that turns into the quotient.
	lhs_pkg::word_t               rem_q;
	lhs_pkg::word_t               dvd_q;
	logic [lhs_pkg::CNT_W-1:0]    bit_cnt_q;

	// Output word registers.
	logic                         out_valid_q;
	logic                         accepted_q;
	lhs_pkg::word_t               count_out_q;
	lhs_pkg::word_t               min_out_q;
	lhs_pkg::word_t               max_out_q;
	lhs_pkg::word_t               sum_out_q;
	lhs_pkg::word_t               mean_out_q;
	lhs_pkg::word_t               lost_out_q;
	lhs_pkg::word_t               hist_out_q [lhs_pkg::BIN_SLOTS];

	logic                         in_take;
	logic                         out_take;
	logic                         out_load;
	logic                         cfg_write;
	logic [lhs_pkg::EDGE_IDX_W-1:0] cfg_idx;
	logic [lhs_pkg::DATA_W:0]     sum_ext;
	logic                         ok;
	logic                         first;
	logic [lhs_pkg::BIN_SLOTS-1:0] bin_hot;
	logic [lhs_pkg::DATA_W:0]     shifted;
	logic [lhs_pkg::DATA_W:0]     diff;
	logic                         ge;
	lhs_pkg::word_t               rem_nxt;

	// Handshakes and the register port.
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_load  = (state_q == S_HOLD) && (!out_valid_q || !out_stall);
	assign in_stall  = (state_q != S_IDLE);
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = paddr[lhs_pkg::ADDR_W-1:2];
	assign prdata    = edge_q[cfg_idx];

	// Overflow check on the running sum, and whether this is a first sample.
	assign sum_ext = {1'b0, acc_sum_q} + {1'b0, sample};
	assign ok      = !sum_ext[lhs_pkg::DATA_W];
	assign first   = (acc_count_q == '0);

	// Bin selection: the first active edge at or above the sample wins.
	always_comb begin
		logic found;
		found = 1'b0;
		for (int i = 0; i < lhs_pkg::EDGE_SLOTS; i++) begin
			logic hit;
			hit = (i >= NUM_EDGES) || (sample <= edge_q[i]);
			bin_hot[i] = hit && !found;
			found = found || hit;
		end
		bin_hot[lhs_pkg::BIN_OVER] = !found;
	end

	// One restoring divide step: shift in a dividend bit, subtract if it fits.
	assign shifted = {rem_q, dvd_q[lhs_pkg::DATA_W-1]};
	assign diff    = shifted - {1'b0, acc_count_q};
	assign ge      = (shifted >= {1'b0, acc_count_q});
	assign rem_nxt = ge ? diff[lhs_pkg::DATA_W-1:0] : shifted[lhs_pkg::DATA_W-1:0];

	// Edge registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lhs_pkg::EDGE_SLOTS; i++) begin
				edge_q[i] <= '1;
			end
		end else if (cfg_write) begin
			edge_q[cfg_idx] <= pwdata;
		end
	end

	// Sequencer, statistics and the output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			acc_count_q <= '0;
			acc_min_q   <= '0;
			acc_max_q   <= '0;
			acc_sum_q   <= '0;
			lost_q      <= '0;
			ok_q        <= 1'b0;
			rem_q       <= '0;
			dvd_q       <= '0;
			bit_cnt_q   <= '0;
			accepted_q  <= 1'b0;
			count_out_q <= '0;
			min_out_q   <= '0;
			max_out_q   <= '0;
			sum_out_q   <= '0;
			mean_out_q  <= '0;
			lost_out_q  <= '0;
			for (int i = 0; i < lhs_pkg::BIN_SLOTS; i++) begin
				bin_q[i]      <= '0;
				hist_out_q[i] <= '0;
			end
		end else begin
			if (out_take && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						ok_q <= ok;
						if (ok) begin
							acc_min_q   <= (first || sample < acc_min_q) ? sample : acc_min_q;
							acc_max_q   <= (first || sample > acc_max_q) ? sample : acc_max_q;
							acc_sum_q   <= sum_ext[lhs_pkg::DATA_W-1:0];
							acc_count_q <= acc_count_q + lhs_pkg::word_t'(1);
							for (int i = 0; i < lhs_pkg::BIN_SLOTS; i++) begin
								if (bin_hot[i]) begin
									bin_q[i] <= bin_q[i] + lhs_pkg::word_t'(1);
								end
							end
							dvd_q <= sum_ext[lhs_pkg::DATA_W-1:0];
						end else begin
							lost_q <= lost_q + lhs_pkg::word_t'(1);
							dvd_q  <= acc_sum_q;
						end
						rem_q     <= '0;
						bit_cnt_q <= lhs_pkg::CNT_W'(lhs_pkg::DATA_W - 1);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q     <= rem_nxt;
					dvd_q     <= {dvd_q[lhs_pkg::DATA_W-2:0], ge};
					bit_cnt_q <= bit_cnt_q - lhs_pkg::CNT_W'(1);
					if (bit_cnt_q == '0) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					// Load the word once the previous one has gone.
					if (out_load) begin
						out_valid_q <= 1'b1;
						accepted_q  <= ok_q;
						count_out_q <= acc_count_q;
						min_out_q   <= acc_min_q;
						max_out_q   <= acc_max_q;
						sum_out_q   <= acc_sum_q;
						mean_out_q  <= first ? '0 : dvd_q;
						lost_out_q  <= lost_q;
						for (int i = 0; i < lhs_pkg::BIN_SLOTS; i++) begin
							hist_out_q[i] <= bin_q[i];
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign sample_count = count_out_q;
	assign min_value    = min_out_q;
	assign max_value    = max_out_q;
	assign total        = sum_out_q;
	assign mean         = mean_out_q;
	assign dropped      = lost_out_q;
	assign hist_0       = hist_out_q[0];
	assign hist_1       = hist_out_q[1];
	assign hist_2       = hist_out_q[2];
	assign hist_3       = hist_out_q[3];
	assign hist_over    = hist_out_q[lhs_pkg::BIN_OVER];

	// A taken sample always starts the divider.
	a_take_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == S_DIV)
		else $error("sample taken but divider not started");

	// The last divide step hands over to the output stage.
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && bit_cnt_q == '0) |=> state_q == S_HOLD)
		else $error("divider ran past its last step");

	// A word is only raised from the output stage.
	a_valid_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_HOLD))
		else $error("output word raised outside the output stage");

	// The mean never exceeds the sum, and minimum never exceeds maximum.
	a_word_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (mean_out_q <= sum_out_q) &&
			(count_out_q == '0 || min_out_q <= max_out_q))
		else $error("inconsistent statistics in output word");

endmodule

// File: verif/latency_histogram_stats_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram statistics unit testbench
// Streams latency samples through the unit under several histogram edge
// settings, predicts every statistics word in step and compares each result
// word field by field. The sender runs in random bursts, the receiver stalls
// on shifting patterns and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;

	localparam lhs_pkg::word_t ALL_ONES = '1;

	// Edge registers in register map order.
	typedef enum int {EDGE_0_REG, EDGE_1_REG, EDGE_2_REG, EDGE_3_REG} edge_reg_t;

	// Receiver stall patterns.
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct {
		logic           accepted;
		lhs_pkg::word_t sample_count;
		lhs_pkg::word_t min_value;
		lhs_pkg::word_t max_value;
		lhs_pkg::word_t total;
		lhs_pkg::word_t mean;
		lhs_pkg::word_t dropped;
		lhs_pkg::word_t hist_0;
		lhs_pkg::word_t hist_1;
		lhs_pkg::word_t hist_2;
		lhs_pkg::word_t hist_3;
		lhs_pkg::word_t hist_over;
	} stats_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [lhs_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_stall;
	lhs_pkg::word_t             sample;
	logic                       out_valid;
	logic                       out_stall;
	logic                       accepted;
	lhs_pkg::word_t             sample_count;
	lhs_pkg::word_t             min_value;
	lhs_pkg::word_t             max_value;
	lhs_pkg::word_t             total;
	lhs_pkg::word_t             mean;
	lhs_pkg::word_t             dropped;
	lhs_pkg::word_t             hist_0;
	lhs_pkg::word_t             hist_1;
	lhs_pkg::word_t             hist_2;
	lhs_pkg::word_t             hist_3;
	lhs_pkg::word_t             hist_over;

	// Samples waiting to be offered, and statistics words still owed by the unit.
	lhs_pkg::word_t pending_samples[$];
	stats_t         stats_due[$];

	// Shadow of the unit's edge registers and running statistics.
	lhs_pkg::word_t edge_cfg[lhs_pkg::EDGE_SLOTS];
	lhs_pkg::word_t stat_count;
	lhs_pkg::word_t stat_min;
	lhs_pkg::word_t stat_max;
	lhs_pkg::word_t stat_sum;
	lhs_pkg::word_t stat_lost;
	lhs_pkg::word_t bin_tally[lhs_pkg::BIN_SLOTS];

	logic        word_taken;
	logic        hold_off;
	int          burst_left;
	int          gap_left;
	stall_mode_t stall_mode;
	int          stall_left;
	int          words_in;
	int          words_out;
	int          error_count;
	int          settings_used;

	latency_histogram_stats_unit DUT (.*);

	always #5 clk = ~clk;

	// Prints one line per mismatch and counts them all.
	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input lhs_pkg::word_t got_v,
			input lhs_pkg::word_t want_v);
		if (got_v !== want_v) begin
			flag_error($sformatf("result %0d: %s is %h, expected %h",
				words_out, name, got_v, want_v));
		end
	endtask

	// Folds one sample into the running statistics and returns the word that
	// the unit should report for it.
	task automatic account_sample(input lhs_pkg::word_t s, output stats_t r);
		int unsigned    b;
		lhs_pkg::word_t lim;
		if (s > ALL_ONES - stat_sum) begin
			stat_lost++;
			r.accepted = 1'b0;
		end else begin
			r.accepted = 1'b1;
			if (stat_count == 0) begin
				stat_min = s;
				stat_max = s;
			end else begin
				if (s < stat_min) stat_min = s;
				if (s > stat_max) stat_max = s;
			end
			// The first edge at or above the sample wins, in register order.
			b = lhs_pkg::BIN_OVER;
			for (int i = lhs_pkg::EDGE_SLOTS - 1; i >= 0; i--) begin
				lim = (i >= lhs_pkg::NUM_EDGES) ? ALL_ONES : edge_cfg[i];
				if (s <= lim) b = i;
			end
			bin_tally[b]++;
			stat_sum += s;
			stat_count++;
		end
		r.sample_count = stat_count;
		r.min_value    = stat_min;
		r.max_value    = stat_max;
		r.total        = stat_sum;
		r.mean         = (stat_count != 0) ? stat_sum / stat_count : '0;
		r.dropped      = stat_lost;
		r.hist_0       = bin_tally[0];
		r.hist_1       = bin_tally[1];
		r.hist_2       = bin_tally[2];
		r.hist_3       = bin_tally[3];
		r.hist_over    = bin_tally[lhs_pkg::BIN_OVER];
	endtask

	// Mostly small samples so that the sum lasts the whole run; samples with
	// the top bit set are always dropped once half the range is used up.
	function automatic lhs_pkg::word_t random_sample();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 6) return {1'b1, 31'($urandom)};
		if (pick < 12) return lhs_pkg::word_t'($urandom_range(0, 1 << 20));
		if (pick < 17) return '0;
		return $urandom & ((32'd1 << $urandom_range(1, 14)) - 1);
	endfunction

	function automatic lhs_pkg::word_t random_edge();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) return ALL_ONES;
		if (pick < 16) return '0;
		return $urandom & ((32'd1 << $urandom_range(1, 20)) - 1);
	endfunction

	// Waits until every sample has been taken and every word has come back.
	task automatic wait_drained(input int limit);
		int waited;
		waited = 0;
		while ((pending_samples.size() != 0 || in_valid || stats_due.size() != 0)
				&& waited < limit) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_edge(input edge_reg_t idx, input lhs_pkg::word_t value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lhs_pkg::ADDR_W'(int'(idx) * 4);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		edge_cfg[idx] = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_edges(input lhs_pkg::word_t e0, input lhs_pkg::word_t e1,
			input lhs_pkg::word_t e2, input lhs_pkg::word_t e3);
		wait_drained(1 << 30);
		write_edge(EDGE_0_REG, e0);
		write_edge(EDGE_1_REG, e1);
		write_edge(EDGE_2_REG, e2);
		write_edge(EDGE_3_REG, e3);
		settings_used++;
	endtask

	task automatic queue_random(input int n);
		repeat (n) pending_samples.push_back(random_sample());
	endtask

	// Sender: bursts of words with random gaps; no gaps while the receiver
	// holds off, so that the unit backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_taken) begin
			if (gap_left != 0 && !hold_off) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_samples.size() != 0) begin
				in_valid <= 1'b1;
				sample   <= pending_samples.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: the stall pattern is picked anew whenever its random countdown runs out.
	always @(negedge clk) begin : stall_gen
		logic stall_now;
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:     stall_now = 1'b0;
			STALL_LIGHT:    stall_now = ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    stall_now = ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: stall_now = (stall_left % 16 < 7);
			default:        stall_now = 1'b0;
		endcase
		out_stall <= hold_off || stall_now;
	end

	// Monitor: predicts on each accepted sample word and checks each result word.
	always @(posedge clk) begin : monitor
		stats_t got;
		stats_t want;
		if (arst_n) begin
			word_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				account_sample(sample, want);
				stats_due.push_back(want);
				words_in++;
			end
			if (out_valid && !out_stall) begin
				got.accepted     = accepted;
				got.sample_count = sample_count;
				got.min_value    = min_value;
				got.max_value    = max_value;
				got.total        = total;
				got.mean         = mean;
				got.dropped      = dropped;
				got.hist_0       = hist_0;
				got.hist_1       = hist_1;
				got.hist_2       = hist_2;
				got.hist_3       = hist_3;
				got.hist_over    = hist_over;
				if (stats_due.size() == 0) begin
					flag_error($sformatf("result word %0d arrived with none outstanding",
						words_out));
				end else begin
					want = stats_due.pop_front();
					check_field("accepted", got.accepted, want.accepted);
					check_field("sample_count", got.sample_count, want.sample_count);
					check_field("min_value", got.min_value, want.min_value);
					check_field("max_value", got.max_value, want.max_value);
					check_field("total", got.total, want.total);
					check_field("mean", got.mean, want.mean);
					check_field("dropped", got.dropped, want.dropped);
					check_field("hist_0", got.hist_0, want.hist_0);
					check_field("hist_1", got.hist_1, want.hist_1);
					check_field("hist_2", got.hist_2, want.hist_2);
					check_field("hist_3", got.hist_3, want.hist_3);
					check_field("hist_over", got.hist_over, want.hist_over);
				end
				words_out++;
			end
		end
	end

	// One long receiver hold-off part way through the run.
	initial begin
		wait (words_in >= 150);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (500) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Stimulus: a directed opening, random phases under several edge
	// settings, and a closing look at the exact sum limit.
	initial begin : stimulus
		lhs_pkg::word_t opening[] = '{32'd0, 32'd5, 32'd10, 32'd11, 32'd100, 32'd101,
			32'd1000, 32'd1001, 32'd100000, 32'd100001, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd3, 32'd7};
		lhs_pkg::word_t headroom;

		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		sample        = '0;
		out_stall     = 1'b0;
		hold_off      = 1'b0;
		word_taken    = 1'b0;
		burst_left    = 0;
		gap_left      = 0;
		stall_mode    = STALL_NONE;
		stall_left    = 0;
		words_in      = 0;
		words_out     = 0;
		error_count   = 0;
		settings_used = 0;
		stat_count    = '0;
		stat_min      = '0;
		stat_max      = '0;
		stat_sum      = '0;
		stat_lost     = '0;
		foreach (edge_cfg[i]) edge_cfg[i] = ALL_ONES;
		foreach (bin_tally[i]) bin_tally[i] = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sorted edges; opening samples sit on and just past each edge, then
		// a large sample is kept and the next two overflow the sum.
		set_edges(32'd10, 32'd100, 32'd1000, 32'd100000);
		foreach (opening[i]) pending_samples.push_back(opening[i]);
		queue_random(80);

		// Unsorted edges: earlier bins shadow later ones.
		set_edges(32'd5000, 32'd100, 32'd60000, 32'd20);
		queue_random(100);

		set_edges('0, '0, '0, '0);
		queue_random(80);

		set_edges(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		queue_random(60);

		set_edges('0, 32'd1000, ALL_ONES, '0);
		queue_random(80);

		repeat (3) begin
			set_edges(random_edge(), random_edge(), random_edge(), random_edge());
			queue_random(70);
		end

		// Sum limit: one past the headroom is dropped, the exact headroom is
		// kept, after which only zero still fits.
		wait_drained(1 << 30);
		headroom = ALL_ONES - stat_sum;
		pending_samples.push_back(headroom + 1);
		pending_samples.push_back(headroom);
		pending_samples.push_back(32'd1);
		pending_samples.push_back('0);
		pending_samples.push_back(ALL_ONES);

		wait_drained(20000);
		repeat (50) @(posedge clk);
		if (stats_due.size() != 0) begin
			flag_error($sformatf("%0d result words never arrived", stats_due.size()));
		end

		$display("Run covered %0d samples (%0d dropped on sum overflow) under %0d edge settings.",
			words_in, stat_lost, settings_used);
		$display("Checked %0d result words, %0d mismatches.", words_out, error_count);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
